// ===== src/json_code_field_extractor_core_assert.svh =====
// ----------------------------------------------------------------------------
// json_code_field_extractor_core_assert.svh
// Assertion macros shared by the extractor RTL. Each macro expects the
// enclosing module to have the signals clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef JSON_CODE_FIELD_EXTRACTOR_CORE_ASSERT_SVH
`define JSON_CODE_FIELD_EXTRACTOR_CORE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define JCFE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jcfe implication check failed");

// Condition that must never be true outside reset.
`define JCFE_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("jcfe forbidden condition seen");

// Consequence required on the next clock edge.
`define JCFE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jcfe next-cycle check failed");

`endif

// ===== src/jcfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcfe_pkg
// Types, character codes and limits shared by the field extractor modules.
// ----------------------------------------------------------------------------
package jcfe_pkg;

	localparam logic [7:0] CHAR_QUOTE = 8'h22;
	localparam logic [7:0] CHAR_C     = 8'h63;
	localparam logic [7:0] CHAR_O     = 8'h6F;
	localparam logic [7:0] CHAR_D     = 8'h64;
	localparam logic [7:0] CHAR_E     = 8'h65;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam int          MAG_W       = 31;
	localparam int          CODE_W      = 32;
	localparam logic [30:0] MAG_MAX     = 31'h7FFF_FFFF;
	localparam logic [30:0] MAG_LIMIT10 = MAG_MAX / 31'd10;
	localparam logic [3:0]  MAG_LAST_D  = 4'(MAG_MAX % 31'd10);
	localparam logic [31:0] UNKNOWN_RST = 32'hFFFF_FFFF;

	localparam int          QUEUE_DEPTH_DEF = 4;

	// Key "code" including both quotes: positions 0..5.
	localparam logic [2:0]  KEY_LAST_POS = 3'd5;

	typedef enum logic [3:0] {
		CLS_QUOTE,
		CLS_C,
		CLS_O,
		CLS_D,
		CLS_E,
		CLS_COLON,
		CLS_MINUS,
		CLS_DIGIT,
		CLS_WS,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] digit;
		logic       last;
	} item_t;

	typedef enum logic [4:0] {
		PH_SEARCH     = 5'b00001,
		PH_PRE_COLON  = 5'b00010,
		PH_POST_COLON = 5'b00100,
		PH_NUMBER     = 5'b01000,
		PH_DONE       = 5'b10000
	} phase_t;

	// Class expected at a given position of the quoted key.
	function automatic cls_t key_cls(input logic [2:0] pos);
		cls_t c;
		unique case (pos)
			3'd0:    c = CLS_QUOTE;
			3'd1:    c = CLS_C;
			3'd2:    c = CLS_O;
			3'd3:    c = CLS_D;
			3'd4:    c = CLS_E;
			3'd5:    c = CLS_QUOTE;
			default: c = CLS_OTHER;
		endcase
		return c;
	endfunction

endpackage

// ===== src/jcfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcfe_front
// Input side: takes body bytes, sorts each into a character class with its
// digit value, and pushes the tagged byte into the queue.
// ----------------------------------------------------------------------------
module jcfe_front
	import jcfe_pkg::*;
(
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] body_byte,
	input  logic       last_byte,
	output logic       push_valid,
	output item_t      push_item,
	input  logic       queue_full
);

	cls_t cls;

	always_comb begin
		if (body_byte >= CHAR_ZERO && body_byte <= CHAR_NINE) begin
			cls = CLS_DIGIT;
		end else if (body_byte == CHAR_SPACE ||
				(body_byte >= CHAR_TAB && body_byte <= CHAR_CR)) begin
			cls = CLS_WS;
		end else begin
			unique case (body_byte)
				CHAR_QUOTE: cls = CLS_QUOTE;
				CHAR_C:     cls = CLS_C;
				CHAR_O:     cls = CLS_O;
				CHAR_D:     cls = CLS_D;
				CHAR_E:     cls = CLS_E;
				CHAR_COLON: cls = CLS_COLON;
				CHAR_MINUS: cls = CLS_MINUS;
				default:    cls = CLS_OTHER;
			endcase
		end
	end

	assign push_item.cls   = cls;
	assign push_item.digit = body_byte[3:0];
	assign push_item.last  = last_byte;
	assign push_valid      = in_valid;
	assign in_stall        = queue_full;

endmodule

// ===== src/jcfe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcfe_queue
// Small register queue of classified bytes between front and back; push and
// pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`include "json_code_field_extractor_core_assert.svh"

module jcfe_queue
	import jcfe_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  item_t push_item,
	output logic  full,
	output logic  pop_valid,
	output item_t pop_item,
	input  logic  pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign full      = (count_q == CNT_FULL);
	assign pop_valid = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];
	assign push      = push_valid && !full;
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`JCFE_ASSERT_NEVER(a_count_range, count_q > CNT_FULL)
	`JCFE_ASSERT_NEXT(a_push_only_grows, push && !pop, count_q == $past(count_q) + 1'b1)
	`JCFE_ASSERT_IMP(a_ptr_gap, count_q == '0 || count_q == CNT_FULL, wr_ptr_q == rd_ptr_q)

endmodule

// ===== src/jcfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcfe_back
// Parse side: key match, colon and sign handling, saturating decimal
// accumulation, and the registered result on the last byte of a body.
// ----------------------------------------------------------------------------
`include "json_code_field_extractor_core_assert.svh"

module jcfe_back
	import jcfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	input  item_t                pop_item,
	output logic                 pop_ready,
	input  logic                 unknown_code_we,
	input  logic [CODE_W-1:0]    unknown_code_wdata,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [CODE_W-1:0] app_code,
	output logic                 code_found
);

	phase_t            phase_q, phase_d;
	logic [2:0]        key_cnt_q, key_cnt_d;
	logic              neg_q, neg_d;
	logic [MAG_W-1:0]  mag_q, mag_d;
	logic              seen_q, seen_d;
	logic [CODE_W-1:0] unknown_q;
	logic              out_valid_q;
	logic [CODE_W-1:0] code_q;
	logic              found_q;

	logic              take;
	logic [MAG_W-1:0]  mag_add;
	logic              mag_sat;
	logic [CODE_W-1:0] result;

	assign pop_ready = !out_valid_q || !out_stall;
	assign take      = pop_valid && pop_ready;

	// Times ten by shift and add; saturate before the product can overflow.
	assign mag_add = {mag_q[MAG_W-4:0], 3'b000} + {mag_q[MAG_W-2:0], 1'b0} +
			MAG_W'(pop_item.digit);
	assign mag_sat = (mag_q > MAG_LIMIT10) ||
			(mag_q == MAG_LIMIT10 && pop_item.digit > MAG_LAST_D);

	always_comb begin
		phase_d   = phase_q;
		key_cnt_d = key_cnt_q;
		neg_d     = neg_q;
		mag_d     = mag_q;
		seen_d    = seen_q;
		unique case (phase_q)
			PH_SEARCH: begin
				if (pop_item.cls == key_cls(key_cnt_q)) begin
					if (key_cnt_q == KEY_LAST_POS) begin
						phase_d   = PH_PRE_COLON;
						key_cnt_d = '0;
					end else begin
						key_cnt_d = key_cnt_q + 1'b1;
					end
				end else begin
					key_cnt_d = (pop_item.cls == CLS_QUOTE) ? 3'd1 : 3'd0;
				end
			end
			PH_PRE_COLON: begin
				if (pop_item.cls == CLS_COLON) begin
					phase_d = PH_POST_COLON;
				end else if (pop_item.cls != CLS_WS) begin
					phase_d = PH_DONE;
				end
			end
			PH_POST_COLON: begin
				case (pop_item.cls)
					CLS_WS: ;
					CLS_MINUS: begin
						neg_d   = 1'b1;
						phase_d = PH_NUMBER;
					end
					CLS_DIGIT: begin
						seen_d  = 1'b1;
						mag_d   = mag_sat ? MAG_MAX : mag_add;
						phase_d = PH_NUMBER;
					end
					default: phase_d = PH_DONE;
				endcase
			end
			PH_NUMBER: begin
				if (pop_item.cls == CLS_DIGIT) begin
					seen_d = 1'b1;
					mag_d  = mag_sat ? MAG_MAX : mag_add;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_DONE: ;
			default: phase_d = PH_DONE;
		endcase
	end

	always_comb begin
		if (!seen_d) begin
			result = unknown_q;
		end else if (neg_d) begin
			result = '0 - {1'b0, mag_d};
		end else begin
			result = {1'b0, mag_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SEARCH;
			key_cnt_q   <= '0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			seen_q      <= 1'b0;
			unknown_q   <= UNKNOWN_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (unknown_code_we) begin
				unknown_q <= unknown_code_wdata;
			end
			if (take && pop_item.last) begin
				// End of body: clear the parse for the next one.
				phase_q   <= PH_SEARCH;
				key_cnt_q <= '0;
				neg_q     <= 1'b0;
				mag_q     <= '0;
				seen_q    <= 1'b0;
			end else if (take) begin
				phase_q   <= phase_d;
				key_cnt_q <= key_cnt_d;
				neg_q     <= neg_d;
				mag_q     <= mag_d;
				seen_q    <= seen_d;
			end
			if (take && pop_item.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && pop_item.last) begin
			code_q  <= result;
			found_q <= seen_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign app_code   = code_q;
	assign code_found = found_q;

	`JCFE_ASSERT_IMP(a_search_clean, phase_q == PH_SEARCH, !neg_q && !seen_q && mag_q == '0)
	`JCFE_ASSERT_IMP(a_number_entered, phase_q == PH_NUMBER, neg_q || seen_q)
	`JCFE_ASSERT_NEVER(a_key_count, key_cnt_q > KEY_LAST_POS)
	`JCFE_ASSERT_NEXT(a_last_emits, take && pop_item.last, out_valid_q && phase_q == PH_SEARCH)

endmodule

// ===== src/json_code_field_extractor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_code_field_extractor_core
// Pulls the signed integer value of the first "code" key out of a JSON body.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one body byte per transaction
//   with last_byte marking the final byte of a body. Output channel
//   (out_valid / out_stall) carries one result per body: app_code and
//   code_found, produced only for a transaction whose last_byte is 1.
//   unknown_code_we / unknown_code_wdata write the value reported when no
//   digit was parsed; write it only while the block is idle.
//   Throughput: one byte per cycle while no stalled result holds the back
//   end. A result passes the queue, then the output register: the queue
//   write comes at the accepting edge of its last byte, and the parse step
//   loads the output register when the back end takes that byte.
//   A stalled result holds in the output register; bytes keep entering until
//   the queue of QUEUE_DEPTH entries fills, then in_stall rises.
//   Reset clears the queue, the parse state and the output valid, and sets
//   unknown_code to -1.
// ----------------------------------------------------------------------------
module json_code_field_extractor_core
	import jcfe_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               body_byte,
	input  logic                     last_byte,
	input  logic                     unknown_code_we,
	input  logic [CODE_W-1:0]        unknown_code_wdata,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [CODE_W-1:0] app_code,
	output logic                     code_found
);

	logic  push_valid;
	item_t push_item;
	logic  queue_full;
	logic  pop_valid;
	item_t pop_item;
	logic  pop_ready;

	jcfe_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.body_byte  (body_byte),
		.last_byte  (last_byte),
		.push_valid (push_valid),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	jcfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.full       (queue_full),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	jcfe_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.pop_valid          (pop_valid),
		.pop_item           (pop_item),
		.pop_ready          (pop_ready),
		.unknown_code_we    (unknown_code_we),
		.unknown_code_wdata (unknown_code_wdata),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.app_code           (app_code),
		.code_found         (code_found)
	);

endmodule
